/* sv/spa_pkg.sv */
// Shared constants, types and state codes of the sparse accumulator.
`default_nettype none

package spa_pkg;

  // Geometry of the accumulator store and the pattern list.
  localparam int NUM_VERTICES = 4096;
  localparam int ADDR_W       = $clog2(NUM_VERTICES);
  localparam int CNT_W        = ADDR_W + 1;
  localparam int IDX_W        = 12;
  localparam int CMP_W        = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam int VAL_W        = 32;
  localparam int PROD_W       = 2 * VAL_W;

  // Operation codes carried by an input word.
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_EDGE  = 2'd1;
  localparam logic [1:0] OP_DRAIN = 2'd2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIT  = 2'd2;

  // Result status codes.
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_SAT   = 2'd2;

  // Q16.16 constants.
  localparam logic signed [VAL_W-1:0] Q_ONE  = 32'sh0001_0000;
  localparam logic signed [VAL_W-1:0] Q_ZERO = 32'sh0000_0000;
  localparam logic signed [VAL_W-1:0] Q_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] Q_MIN  = 32'sh8000_0000;

  // One entry of the accumulator store.
  typedef struct packed {
    logic                    present;
    logic                    sat;
    logic signed [VAL_W-1:0] acc;
  } entry_t;

  // Access request to the accumulator store.
  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wdata;
  } ent_req_t;

  // Access request to the pattern list.
  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] wdata;
  } pat_req_t;

  // Operands handed to the fixed-point multiplier.
  typedef struct packed {
    logic                    en;
    logic signed [VAL_W-1:0] a;
    logic signed [VAL_W-1:0] b;
  } qmul_req_t;

  // Rounded and saturated product.
  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    sat;
  } qmul_res_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_MUL2,
    S_UPD,
    S_DIDX,
    S_EMIT
  } state_t;

endpackage

`default_nettype wire

/* sv/spa_channels.sv */
// Handshake channel interfaces: input word, result word and register write.
`default_nettype none

interface spa_item_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          operation;
  logic [spa_pkg::IDX_W-1:0]           vertex_index;
  logic signed [spa_pkg::VAL_W-1:0]    operand_value;
  logic signed [spa_pkg::VAL_W-1:0]    edge_weight;

  modport source (output valid, operation, vertex_index, operand_value, edge_weight,
                  input ready);
  modport sink   (input valid, operation, vertex_index, operand_value, edge_weight,
                  output ready);
endinterface

interface spa_result_if;
  logic                                valid;
  logic                                ready;
  logic [spa_pkg::IDX_W-1:0]           out_index;
  logic signed [spa_pkg::VAL_W-1:0]    out_value;
  logic                                last_entry;
  logic [1:0]                          status;

  modport source (output valid, out_index, out_value, last_entry, status,
                  input ready);
  modport sink   (input valid, out_index, out_value, last_entry, status,
                  output ready);
endinterface

interface spa_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [spa_pkg::CFG_IDX_W-1:0]       index;
  logic [spa_pkg::VAL_W-1:0]           data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* sv/spa_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module spa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic                       re,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr,
  output logic      [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* sv/spa_qmul.sv */
// Q16.16 multiplier: registered product, then round half up and saturate.
`default_nettype none

module spa_qmul (
  input  wire logic                clk,
  input  wire spa_pkg::qmul_req_t  req,
  output spa_pkg::qmul_res_t       res
);

  localparam logic signed [spa_pkg::PROD_W-1:0] ROUND_HALF = 64'sd32768;
  localparam logic signed [spa_pkg::PROD_W-1:0] P_MAX =
    spa_pkg::PROD_W'(spa_pkg::Q_MAX);
  localparam logic signed [spa_pkg::PROD_W-1:0] P_MIN =
    spa_pkg::PROD_W'(spa_pkg::Q_MIN);

  logic signed [spa_pkg::PROD_W-1:0] prod;
  logic signed [spa_pkg::PROD_W-1:0] rounded;
  logic signed [spa_pkg::PROD_W-1:0] scaled;

  // Full-width product, captured when the sequencer issues operands.
  always_ff @(posedge clk) begin
    if (req.en) begin
      prod <= req.a * req.b;
    end
  end

  // Round half up, drop sixteen fraction bits and clamp to 32 bits.
  always_comb begin
    rounded = prod + ROUND_HALF;
    scaled  = rounded >>> 16;
    if (scaled > P_MAX) begin
      res.value = spa_pkg::Q_MAX;
      res.sat   = 1'b1;
    end else if (scaled < P_MIN) begin
      res.value = spa_pkg::Q_MIN;
      res.sat   = 1'b1;
    end else begin
      res.value = scaled[spa_pkg::VAL_W-1:0];
      res.sat   = 1'b0;
    end
  end

endmodule

`default_nettype wire

/* sv/spa_ctrl.sv */
// Sequencer: configuration, read-modify-write of the store, pattern list and drain.
`default_nettype none

module spa_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  spa_item_if.sink                  item,
  spa_result_if.source              result,
  spa_cfg_if.sink                   cfg,
  output spa_pkg::ent_req_t         ent_req,
  input  wire spa_pkg::entry_t      ent_rdata,
  output spa_pkg::pat_req_t         pat_req,
  input  wire logic [spa_pkg::ADDR_W-1:0] pat_rdata,
  output spa_pkg::qmul_req_t        mul_req,
  input  wire spa_pkg::qmul_res_t   mul_res
);

  localparam logic [spa_pkg::ADDR_W-1:0] LAST_ADDR =
    spa_pkg::ADDR_W'(spa_pkg::NUM_VERTICES - 1);
  localparam logic [spa_pkg::CNT_W-1:0] CNT_LIMIT =
    spa_pkg::CNT_W'(spa_pkg::NUM_VERTICES);

  spa_pkg::state_t state, state_next;

  // Configuration registers.
  logic signed [spa_pkg::VAL_W-1:0] alpha_gain;
  logic signed [spa_pkg::VAL_W-1:0] beta_gain;
  logic                             unit_weights;

  // Per-item working registers.
  logic [spa_pkg::ADDR_W-1:0]       vaddr;
  logic                             is_edge;
  logic signed [spa_pkg::VAL_W-1:0] weight;
  logic signed [spa_pkg::VAL_W-1:0] amt;
  logic                             amt_sat;
  logic                             empty_drain;
  logic [spa_pkg::ADDR_W-1:0]       didx;

  // List bookkeeping and clearing sweep.
  logic [spa_pkg::CNT_W-1:0]        entry_count;
  logic [spa_pkg::CNT_W-1:0]        drain_pointer;
  logic [spa_pkg::CNT_W-1:0]        ptr_inc;
  logic [spa_pkg::ADDR_W-1:0]       clr_addr;

  // Result register.
  logic                             res_valid;
  logic [spa_pkg::IDX_W-1:0]        res_index;
  logic signed [spa_pkg::VAL_W-1:0] res_value;
  logic                             res_last;
  logic [1:0]                       res_status;

  logic                             item_fire;
  logic                             in_range;
  logic                             list_done;
  logic                             emit_go;
  logic signed [spa_pkg::VAL_W:0]   sum_wide;
  logic signed [spa_pkg::VAL_W-1:0] sum;
  logic                             sum_sat;

  assign item.ready = (state == spa_pkg::S_IDLE);
  assign cfg.ready  = 1'b1;
  assign item_fire  = item.valid && item.ready;
  assign in_range   = spa_pkg::CMP_W'(item.vertex_index) <
                      spa_pkg::CMP_W'(spa_pkg::NUM_VERTICES);
  assign list_done  = (drain_pointer >= entry_count) || (drain_pointer >= CNT_LIMIT);
  assign ptr_inc    = drain_pointer + 1'b1;
  assign emit_go    = !res_valid || result.ready;

  assign result.valid      = res_valid;
  assign result.out_index  = res_index;
  assign result.out_value  = res_value;
  assign result.last_entry = res_last;
  assign result.status     = res_status;

  // Saturating accumulation of the scaled amount into the stored value.
  always_comb begin
    sum_wide = {ent_rdata.acc[spa_pkg::VAL_W-1], ent_rdata.acc} +
               {amt[spa_pkg::VAL_W-1], amt};
    if (sum_wide[spa_pkg::VAL_W] != sum_wide[spa_pkg::VAL_W-1]) begin
      sum     = sum_wide[spa_pkg::VAL_W] ? spa_pkg::Q_MIN : spa_pkg::Q_MAX;
      sum_sat = 1'b1;
    end else begin
      sum     = sum_wide[spa_pkg::VAL_W-1:0];
      sum_sat = 1'b0;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      spa_pkg::S_CLEAR: begin
        if (clr_addr == LAST_ADDR) begin
          state_next = spa_pkg::S_IDLE;
        end
      end
      spa_pkg::S_IDLE: begin
        if (item_fire) begin
          case (item.operation)
            spa_pkg::OP_LOAD, spa_pkg::OP_EDGE: begin
              if (in_range) begin
                state_next = spa_pkg::S_MUL;
              end
            end
            spa_pkg::OP_DRAIN: begin
              state_next = list_done ? spa_pkg::S_EMIT : spa_pkg::S_DIDX;
            end
            default: state_next = spa_pkg::S_IDLE;
          endcase
        end
      end
      spa_pkg::S_MUL: begin
        state_next = (is_edge && !unit_weights) ? spa_pkg::S_MUL2 : spa_pkg::S_UPD;
      end
      spa_pkg::S_MUL2: state_next = spa_pkg::S_UPD;
      spa_pkg::S_UPD:  state_next = spa_pkg::S_IDLE;
      spa_pkg::S_DIDX: state_next = spa_pkg::S_EMIT;
      spa_pkg::S_EMIT: begin
        if (emit_go) begin
          state_next = spa_pkg::S_IDLE;
        end
      end
      default: state_next = spa_pkg::S_IDLE;
    endcase
  end

  // Memory and multiplier requests for each state.
  always_comb begin
    ent_req = '0;
    pat_req = '0;
    mul_req = '0;
    case (state)
      spa_pkg::S_CLEAR: begin
        ent_req.we    = 1'b1;
        ent_req.waddr = clr_addr;
      end
      spa_pkg::S_IDLE: begin
        ent_req.raddr = spa_pkg::ADDR_W'(item.vertex_index);
        pat_req.raddr = drain_pointer[spa_pkg::ADDR_W-1:0];
        mul_req.a     = (item.operation == spa_pkg::OP_LOAD) ? beta_gain : alpha_gain;
        mul_req.b     = item.operand_value;
        if (item_fire) begin
          case (item.operation)
            spa_pkg::OP_LOAD, spa_pkg::OP_EDGE: begin
              ent_req.re = in_range;
              mul_req.en = in_range;
            end
            spa_pkg::OP_DRAIN: pat_req.re = !list_done;
            default: ;
          endcase
        end
      end
      spa_pkg::S_MUL: begin
        mul_req.en = is_edge && !unit_weights;
        mul_req.a  = mul_res.value;
        mul_req.b  = weight;
      end
      spa_pkg::S_UPD: begin
        ent_req.we            = 1'b1;
        ent_req.waddr         = vaddr;
        ent_req.wdata.present = 1'b1;
        ent_req.wdata.sat     = ent_rdata.sat || amt_sat || sum_sat;
        ent_req.wdata.acc     = sum;
        pat_req.we            = !ent_rdata.present;
        pat_req.waddr         = entry_count[spa_pkg::ADDR_W-1:0];
        pat_req.wdata         = vaddr;
      end
      spa_pkg::S_DIDX: begin
        ent_req.re    = 1'b1;
        ent_req.raddr = pat_rdata;
      end
      spa_pkg::S_EMIT: begin
        ent_req.we    = emit_go && !empty_drain;
        ent_req.waddr = didx;
      end
      default: ;
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_gain   <= spa_pkg::Q_ONE;
      beta_gain    <= spa_pkg::Q_ZERO;
      unit_weights <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        spa_pkg::CFG_ALPHA: alpha_gain   <= cfg.data;
        spa_pkg::CFG_BETA:  beta_gain    <= cfg.data;
        spa_pkg::CFG_UNIT:  unit_weights <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // Control state: sequencer, sweep, list counters and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= spa_pkg::S_CLEAR;
      clr_addr      <= '0;
      entry_count   <= '0;
      drain_pointer <= '0;
      res_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (state == spa_pkg::S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == spa_pkg::S_UPD && !ent_rdata.present) begin
        entry_count <= entry_count + 1'b1;
      end
      if (state == spa_pkg::S_EMIT && emit_go) begin
        res_valid <= 1'b1;
        if (empty_drain || ptr_inc >= entry_count) begin
          entry_count   <= '0;
          drain_pointer <= '0;
        end else begin
          drain_pointer <= ptr_inc;
        end
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Working registers and result payload.
  always_ff @(posedge clk) begin
    if (item_fire) begin
      vaddr       <= spa_pkg::ADDR_W'(item.vertex_index);
      is_edge     <= (item.operation == spa_pkg::OP_EDGE);
      weight      <= item.edge_weight;
      empty_drain <= list_done;
    end
    if (state == spa_pkg::S_MUL) begin
      amt     <= mul_res.value;
      amt_sat <= mul_res.sat;
    end
    if (state == spa_pkg::S_MUL2) begin
      amt     <= mul_res.value;
      amt_sat <= amt_sat || mul_res.sat;
    end
    if (state == spa_pkg::S_DIDX) begin
      didx <= pat_rdata;
    end
    if (state == spa_pkg::S_EMIT && emit_go) begin
      if (empty_drain) begin
        res_index  <= '0;
        res_value  <= spa_pkg::Q_ZERO;
        res_last   <= 1'b1;
        res_status <= spa_pkg::STAT_EMPTY;
      end else begin
        res_index  <= spa_pkg::IDX_W'(didx);
        res_value  <= ent_rdata.acc;
        res_last   <= (ptr_inc >= entry_count);
        res_status <= ent_rdata.sat ? spa_pkg::STAT_SAT : spa_pkg::STAT_OK;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/sparse_accumulator_spmspv_top.sv */
// Top level of the sparse accumulator: sequencer, multiplier and the two memories.
//
// The block accumulates y = beta*y + alpha*A^T*x in signed Q16.16 over 4096
// entries held in one synchronous memory, and keeps the order of first touch
// in a second memory. After reset a clearing pass writes every entry of the
// store, one per cycle, so the input accepts nothing until the pass is done;
// register writes are taken at any time. Items are handled one at a time. A
// load, or an edge in unit-weight mode, goes through read and first multiply,
// rounding and write back; an edge with a weight adds a second multiply, as
// its two products go through the one multiplier in turn. A drain goes through
// pattern read, store read and emit, an empty drain straight to emit, and the
// emit waits while the result register holds a word not yet taken. Each item's
// write back ends before the next item reads, so no forwarding is needed.
`default_nettype none

module sparse_accumulator_spmspv_top (
  input  wire logic       clk,
  input  wire logic       rst,
  spa_item_if.sink        item,
  spa_result_if.source    result,
  spa_cfg_if.sink         cfg
);

  spa_pkg::ent_req_t              ent_req;
  spa_pkg::entry_t                ent_rdata;
  spa_pkg::pat_req_t              pat_req;
  logic [spa_pkg::ADDR_W-1:0]     pat_rdata;
  spa_pkg::qmul_req_t             mul_req;
  spa_pkg::qmul_res_t             mul_res;

  // Sequencer.
  spa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .result    (result),
    .cfg       (cfg),
    .ent_req   (ent_req),
    .ent_rdata (ent_rdata),
    .pat_req   (pat_req),
    .pat_rdata (pat_rdata),
    .mul_req   (mul_req),
    .mul_res   (mul_res)
  );

  // Shared fixed-point multiplier.
  spa_qmul u_qmul (
    .clk (clk),
    .req (mul_req),
    .res (mul_res)
  );

  // Accumulator store: presence, saturation mark and value per vertex.
  spa_ram #(
    .WIDTH ($bits(spa_pkg::entry_t)),
    .DEPTH (spa_pkg::NUM_VERTICES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ent_req.we),
    .waddr (ent_req.waddr),
    .wdata (ent_req.wdata),
    .re    (ent_req.re),
    .raddr (ent_req.raddr),
    .rdata (ent_rdata)
  );

  // Pattern list: vertex indexes in order of first touch.
  spa_ram #(
    .WIDTH (spa_pkg::ADDR_W),
    .DEPTH (spa_pkg::NUM_VERTICES)
  ) u_pattern_ram (
    .clk   (clk),
    .we    (pat_req.we),
    .waddr (pat_req.waddr),
    .wdata (pat_req.wdata),
    .re    (pat_req.re),
    .raddr (pat_req.raddr),
    .rdata (pat_rdata)
  );

endmodule

`default_nettype wire

/* sv/spa_checker.sv */
// Port-level checks on the sparse accumulator, bound to its top level.
`default_nettype none

module spa_checker (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           item_ready,
  input  wire logic                           result_valid,
  input  wire logic                           result_ready,
  input  wire logic [spa_pkg::IDX_W-1:0]      out_index,
  input  wire logic [spa_pkg::VAL_W-1:0]      out_value,
  input  wire logic                           last_entry,
  input  wire logic [1:0]                     status
);

  // A word offered and not taken stays offered.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result word withdrawn before it was taken");

  // A word offered and not taken keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      $stable(out_index) && $stable(out_value) && $stable(last_entry) && $stable(status))
    else $error("result payload changed while stalled");

  // An empty drain reports a zero word that closes the list.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && status == spa_pkg::STAT_EMPTY |->
      last_entry && out_index == '0 && out_value == '0)
    else $error("empty drain word malformed");

  // The clearing pass holds the input closed right after reset.
  assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !item_ready)
    else $error("input open during the clearing pass");

endmodule

bind sparse_accumulator_spmspv_top spa_checker u_spa_checker (
  .clk          (clk),
  .rst          (rst),
  .item_ready   (item.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .out_index    (result.out_index),
  .out_value    (result.out_value),
  .last_entry   (result.last_entry),
  .status       (result.status)
);

`default_nettype wire
